// ===== hw/rtl/sleep_timeout_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sleep timeout table assertion macros
// Shared concurrent assertion forms used by the sleep timeout table RTL.
// ----------------------------------------------------------------------------
`ifndef SLEEP_TIMEOUT_TABLE_UNIT_DEFINES_SVH
`define SLEEP_TIMEOUT_TABLE_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define STT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sleep timeout table package
// Widths, codes, sequencer states and shared-unit types of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int STT_SLOTS = 16;   // default table depth
   localparam int TICK_MS   = 55;   // milliseconds per tick
   localparam int MS_W      = 32;   // sleep request width
   localparam int PID_W     = 16;   // process id width
   localparam int CNT_W     = 27;   // remaining tick count width
   localparam int TICKS_W   = 32;   // free-running tick counter width
   localparam int ENTRY_W   = PID_W + CNT_W;

   // Divide by 55 as a reciprocal product:
   // ms / 55 == (ms * (2**32 + TICK_RECIP_LO)) >> DIV_SHIFT for every 32-bit ms.
   localparam int RECIP_W   = 30;   // width of the low part of the reciprocal
   localparam int DIV_SHIFT = 38;   // reciprocal scale
   localparam int PROD_W    = MS_W + RECIP_W;
   localparam logic [RECIP_W-1:0] TICK_RECIP_LO = 30'd702812831;

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_ADD      = 2'd1,
      REQ_SUPPRESS = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_WOKEN = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_EX,
      ST_ADD_SCAN,
      ST_ADD_DIV,
      ST_ADD_WR,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]   operand;
   } alu_req_type;

   typedef struct packed {
      logic [CNT_W-1:0]   diff;   // operand minus one
      logic               ge;     // operand is nonzero
   } alu_res_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stt_ram.sv =====
// ----------------------------------------------------------------------------
// Sleep timeout table RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stt_alu.sv =====
// ----------------------------------------------------------------------------
// Sleep timeout table shared subtract unit
// One decrement and zero compare, reused for every used slot of the tick walk.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_alu
   import stt_pkg::*;
(
   input  wire alu_req_type alu_req,
   output alu_res_type      alu_res
);

   logic [CNT_W:0]   diff_full;

   always_comb begin
      diff_full    = {1'b0, alu_req.operand} - (CNT_W+1)'(1);
      alu_res.diff = diff_full[CNT_W-1:0];
      alu_res.ge   = ~diff_full[CNT_W];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sleep_timeout_table_unit.sv =====
// Sequence: a suppress, an unused code or a suppressed tick goes straight to the result;
//   a tick reads each slot and decrements or wakes each used one; an add scans for the
//   first free slot, then divides and writes it; an add to a full table ends the scan.
// Throughput: one transaction at a time; the next is taken in the cycle after the final
//   result is loaded, and a result the receiver holds off stalls the sequencer in place.
// Reset (synchronous, active high) empties the table and zeroes counter and flag.
// ----------------------------------------------------------------------------
// Sleep timeout table unit
// Table of sleeping process ids with tick countdowns and a wrapping tick
// counter, run by a small sequencer over one shared subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sleep_timeout_table_unit_defines.svh"

module sleep_timeout_table_unit
   import stt_pkg::*;
#(
   parameter int SLOTS = STT_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [31:0] sleep_ms, [47:32] proc_id
   input  wire logic [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] woken_id, [47:16] elapsed_ticks
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast    // last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type           state_ff,      state_in;
   logic [SLOTS-1:0]    used_ff,       used_in;
   logic [TICKS_W-1:0]  tick_ff,       tick_in;
   logic                skip_ff,       skip_in;
   logic [IDX_W-1:0]    idx_ff,        idx_in;
   status_type          status_ff,     status_in;
   logic                hold_valid_ff, hold_valid_in;
   logic [PID_W-1:0]    hold_pid_ff,   hold_pid_in;
   logic [MS_W-1:0]     dividend_ff,   dividend_in;
   logic [PROD_W-1:0]   prod_ff,       prod_in;
   logic [PID_W-1:0]    pid_ff,        pid_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [47:0]         rsp_data_ff,   rsp_data_in;
   logic [1:0]          rsp_user_ff,   rsp_user_in;
   logic                rsp_last_ff,   rsp_last_in;

   // ------------------------------------------------------------------------
   // Control and datapath wires
   // ------------------------------------------------------------------------
   logic                req_fire;
   req_kind_type        req_kind;
   logic                can_push;
   logic                idx_last;
   logic                slot_used;
   logic                wake;
   logic                tick_stall;

   logic                ram_rd_en;
   logic                ram_wr_en;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [PID_W-1:0]    rd_pid;
   logic [CNT_W-1:0]    rd_remaining;

   alu_req_type         alu_req;
   alu_res_type         alu_res;
   logic [2*MS_W:0]     recip_sum;
   logic [CNT_W-1:0]    quot;

   logic                push_en;
   status_type          push_status;
   logic [PID_W-1:0]    push_pid;
   logic                push_last;

   assign req_fire     = req_tvalid && req_tready;
   assign req_kind     = req_kind_type'(req_tuser);
   // Output slot is free this cycle, or its transaction completes now.
   assign can_push     = !rsp_valid_ff || rsp_tready;
   assign idx_last     = (idx_ff == LAST_IDX);
   assign slot_used    = used_ff[idx_ff];
   assign rd_pid       = ram_rd_data[ENTRY_W-1:CNT_W];
   assign rd_remaining = ram_rd_data[CNT_W-1:0];
   // In the execute state the unit decrements; a count already at zero wakes.
   assign wake         = !alu_res.ge;
   // A second wake needs the held one pushed out first.
   assign tick_stall   = wake && hold_valid_ff && !can_push;
   // Finish the reciprocal divide: add the 2**32 part of the reciprocal, then
   // take the quotient from above the scale point.
   assign recip_sum    = {1'b0, dividend_ff, {MS_W{1'b0}}} + (2*MS_W+1)'(prod_ff);
   assign quot         = recip_sum[DIV_SHIFT +: CNT_W];

   // ------------------------------------------------------------------------
   // Slot storage: process id over remaining count, one entry per slot
   // ------------------------------------------------------------------------
   stt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Shared subtract unit
   // ------------------------------------------------------------------------
   stt_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  REQ_TICK: state_in = skip_ff ? ST_RESPOND : ST_TICK_RD;
                  REQ_ADD:  state_in = ST_ADD_SCAN;
                  default:  state_in = ST_RESPOND;
               endcase
            end
         end
         ST_TICK_RD: begin
            if (slot_used) begin
               state_in = ST_TICK_EX;
            end else if (idx_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_TICK_EX: begin
            if (!tick_stall) begin
               state_in = idx_last ? ST_RESPOND : ST_TICK_RD;
            end
         end
         ST_ADD_SCAN: begin
            if (!slot_used) begin
               state_in = ST_ADD_DIV;
            end else if (idx_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_ADD_DIV: state_in = ST_ADD_WR;
         ST_ADD_WR:  state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_tready      = 1'b0;
      ram_rd_en       = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_data     = {pid_ff, quot};
      alu_req.operand = rd_remaining;
      push_en         = 1'b0;
      push_status     = STAT_WOKEN;
      push_pid        = hold_pid_ff;
      push_last       = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_TICK_RD: ram_rd_en = slot_used;
         ST_TICK_EX: begin
            if (!wake) begin
               // write back the decremented count
               ram_wr_en   = 1'b1;
               ram_wr_data = {rd_pid, alu_res.diff};
            end else if (hold_valid_ff && can_push) begin
               // flush the earlier wake; it is not the final one
               push_en = 1'b1;
            end
         end
         ST_ADD_WR: ram_wr_en = 1'b1;
         ST_RESPOND: begin
            push_en   = can_push;
            push_last = 1'b1;
            if (!hold_valid_ff) begin
               push_status = status_ff;
               push_pid    = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      used_in       = used_ff;
      tick_in       = tick_ff;
      skip_in       = skip_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      hold_valid_in = hold_valid_ff;
      hold_pid_in   = hold_pid_ff;
      dividend_in   = dividend_ff;
      prod_in       = prod_ff;
      pid_in        = pid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in      = '0;
               status_in   = STAT_DONE;
               dividend_in = req_tdata[MS_W-1:0];
               pid_in      = req_tdata[MS_W+PID_W-1:MS_W];
               case (req_kind)
                  REQ_TICK: begin
                     // advance the counter unless this tick is suppressed
                     if (!skip_ff) begin
                        tick_in = tick_ff + 1'b1;
                     end
                     skip_in = 1'b0;
                  end
                  REQ_SUPPRESS: skip_in = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK_RD: begin
            if (!slot_used && !idx_last) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TICK_EX: begin
            if (!tick_stall) begin
               if (wake) begin
                  // free the slot and hold its pid until we know if it is last
                  used_in[idx_ff] = 1'b0;
                  hold_valid_in   = 1'b1;
                  hold_pid_in     = rd_pid;
               end
               if (!idx_last) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_ADD_SCAN: begin
            if (slot_used) begin
               if (idx_last) begin
                  status_in = STAT_FULL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         // Register the product with the low part of the reciprocal of 55.
         ST_ADD_DIV: prod_in = PROD_W'(dividend_ff) * PROD_W'(TICK_RECIP_LO);
         ST_ADD_WR: used_in[idx_ff] = 1'b1;
         ST_RESPOND: begin
            if (can_push) begin
               hold_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Output register: load on push, drop once the transaction completes
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (push_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {tick_ff, push_pid};
         rsp_user_in  = push_status;
         rsp_last_in  = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         tick_ff       <= '0;
         skip_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         tick_ff       <= tick_in;
         skip_ff       <= skip_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      hold_pid_ff <= hold_pid_in;
      dividend_ff <= dividend_in;
      prod_ff     <= prod_in;
      pid_ff      <= pid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `STT_ASSERT_IMPLIES(a_idle_no_hold, clock, reset, req_tready, !hold_valid_ff, "held wake left over in idle")
   `STT_ASSERT_IMPLIES(a_exec_on_used, clock, reset, state_ff == ST_TICK_EX, slot_used, "count walked on a free slot")
   `STT_ASSERT_IMPLIES(a_div_on_free, clock, reset, state_ff == ST_ADD_DIV, !slot_used, "divide runs for an occupied slot")
   `STT_ASSERT_NEXT(a_add_sets_used, clock, reset, state_ff == ST_ADD_WR, used_ff[$past(idx_ff)], "added slot not marked used")

endmodule

`default_nettype wire
